FILE: rtl/chxy_pkg.sv
// ----------------------------------------------------------------------------
// chxy_pkg: shared types and constants for the compass heading block
// Fixed-point formats, angle constants and the arctangent steps of the
// vectoring CORDIC.
// ----------------------------------------------------------------------------
package chxy_pkg;

  // field and result widths
  localparam int FIELD_W   = 16;
  localparam int HEADING_W = 15;

  // cordic sizing
  localparam int ITERATIONS_DEF = 16;
  localparam int ATAN_ENTRIES   = 24;
  localparam int CORDIC_SHIFT   = 14;   // magnitudes scaled by 2^14
  localparam int DEG_SHIFT      = 22;   // angles in 2^-22 degree
  localparam int CW             = 33;   // signed x/y datapath width
  localparam int ZW             = 31;   // signed angle accumulator width
  localparam int AW             = 29;   // clamped first-quadrant angle width
  localparam int HW             = 31;   // folded heading width before rounding
  localparam int ROUND_SHIFT    = HW - HEADING_W;

  // angle constants in 2^-22 degree
  localparam logic [AW-1:0] DEG_90  = AW'(90 << DEG_SHIFT);
  localparam logic [HW-1:0] DEG_180 = HW'(180 << DEG_SHIFT);
  localparam logic [HW-1:0] DEG_360 = HW'(360 << DEG_SHIFT);

  // rounding and wrap of the final heading
  localparam logic [HW:0]          ROUND_HALF   = (HW+1)'(1 << (ROUND_SHIFT - 1));
  localparam logic [HEADING_W-1:0] HEADING_FULL = HEADING_W'(23040);

  // atan(2^-i) in degrees, scaled by 2^22 and rounded
  localparam logic [AW-1:0] ATAN_Q22 [ATAN_ENTRIES] = '{
    AW'(188743680), AW'(111421900), AW'(58872272), AW'(29884485),
    AW'(15000234),  AW'(7507429),   AW'(3754631),  AW'(1877430),
    AW'(938729),    AW'(469366),    AW'(234683),   AW'(117342),
    AW'(58671),     AW'(29335),     AW'(14668),    AW'(7334),
    AW'(3667),      AW'(1833),      AW'(917),      AW'(458),
    AW'(229),       AW'(115),       AW'(57),       AW'(29)
  };

  // axis cases that bypass the rotations
  typedef enum logic [1:0] {
    FORCE_NONE,    // general vector, use the cordic angle
    FORCE_ZERO,    // on the x axis (or zero vector): angle 0
    FORCE_RIGHT    // on the y axis: angle 90 degrees
  } force_t;

endpackage

FILE: rtl/chxy_cordic.sv
// ----------------------------------------------------------------------------
// chxy_cordic: pipelined vectoring cordic with quadrant fold and rounding
// One micro-rotation per stage, then clamp, quadrant placement and rounding
// to 1/64 degree. The whole pipeline advances together on en.
// ----------------------------------------------------------------------------
module chxy_cordic #(
  parameter int ITERATIONS = chxy_pkg::ITERATIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_v,
  input  logic signed [chxy_pkg::FIELD_W-1:0] field_x,
  input  logic signed [chxy_pkg::FIELD_W-1:0] field_y,
  output logic                              res_v,
  output logic [chxy_pkg::HEADING_W-1:0]    res_heading
);
  import chxy_pkg::*;

  localparam int NSTAGE = (ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : ITERATIONS;

  // per-stage registers, index 0 is the input stage
  logic                 v_r  [NSTAGE+1];
  logic                 xn_r [NSTAGE+1];
  logic                 yn_r [NSTAGE+1];
  force_t               fc_r [NSTAGE+1];
  logic signed [CW-1:0] cx_r [NSTAGE+1];
  logic signed [CW-1:0] cy_r [NSTAGE+1];
  logic signed [ZW-1:0] z_r  [NSTAGE+1];

  // input stage: magnitudes, signs and axis cases
  logic signed [FIELD_W:0] xe, ye;
  logic [FIELD_W:0]        ax, ay;
  force_t                  fc_nxt;

  always_comb begin
    xe = {field_x[FIELD_W-1], field_x};
    ye = {field_y[FIELD_W-1], field_y};
    ax = xe[FIELD_W] ? unsigned'(-xe) : unsigned'(xe);
    ay = ye[FIELD_W] ? unsigned'(-ye) : unsigned'(ye);
    if (ay == '0) begin
      fc_nxt = FORCE_ZERO;
    end else if (ax == '0) begin
      fc_nxt = FORCE_RIGHT;
    end else begin
      fc_nxt = FORCE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xn_r[0] <= field_x[FIELD_W-1];
      yn_r[0] <= field_y[FIELD_W-1];
      fc_r[0] <= fc_nxt;
      cx_r[0] <= signed'(CW'({ax, {CORDIC_SHIFT{1'b0}}}));
      cy_r[0] <= signed'(CW'({ay, {CORDIC_SHIFT{1'b0}}}));
      z_r[0]  <= '0;
    end
  end

  // micro-rotation stages
  for (genvar i = 0; i < NSTAGE; i++) begin : g_rot
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] step;

    always_comb begin
      dx   = cy_r[i] >>> i;
      dy   = cx_r[i] >>> i;
      step = ZW'(signed'({1'b0, ATAN_Q22[i]}));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xn_r[i+1] <= xn_r[i];
        yn_r[i+1] <= yn_r[i];
        fc_r[i+1] <= fc_r[i];
        if (!cy_r[i][CW-1]) begin
          cx_r[i+1] <= cx_r[i] + dx;
          cy_r[i+1] <= cy_r[i] - dy;
          z_r[i+1]  <= z_r[i] + step;
        end else begin
          cx_r[i+1] <= cx_r[i] - dx;
          cy_r[i+1] <= cy_r[i] + dy;
          z_r[i+1]  <= z_r[i] - step;
        end
      end
    end
  end

  // clamp stage: axis cases and limit to 0..90 degrees
  localparam logic signed [ZW-1:0] DEG_90_Z = ZW'(signed'({1'b0, DEG_90}));

  logic signed [ZW-1:0] zl;
  logic [AW-1:0]        a_nxt, a_r;
  logic                 ca_v_r, ca_xn_r, ca_yn_r;

  always_comb begin
    zl = z_r[NSTAGE];
    case (fc_r[NSTAGE])
      FORCE_ZERO:  a_nxt = '0;
      FORCE_RIGHT: a_nxt = DEG_90;
      FORCE_NONE: begin
        if (zl[ZW-1]) begin
          a_nxt = '0;
        end else if (zl > DEG_90_Z) begin
          a_nxt = DEG_90;
        end else begin
          a_nxt = zl[AW-1:0];
        end
      end
      default:     a_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_v_r <= 1'b0;
    end else if (en) begin
      ca_v_r <= v_r[NSTAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r     <= a_nxt;
      ca_xn_r <= xn_r[NSTAGE];
      ca_yn_r <= yn_r[NSTAGE];
    end
  end

  // quadrant stage: fold into 0..360 degrees
  logic [HW-1:0] ae, h_nxt, h_r;
  logic          qd_v_r;

  always_comb begin
    ae = HW'(a_r);
    if (!ca_xn_r && !ca_yn_r) begin
      h_nxt = ae;
    end else if (ca_xn_r && !ca_yn_r) begin
      h_nxt = DEG_180 - ae;
    end else if (ca_xn_r) begin
      h_nxt = DEG_180 + ae;
    end else begin
      h_nxt = DEG_360 - ae;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qd_v_r <= 1'b0;
    end else if (en) begin
      qd_v_r <= ca_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_r <= h_nxt;
    end
  end

  // rounding stage: half up to 1/64 degree, full turn wraps to zero
  logic [HW:0]          hsum;
  logic [HEADING_W-1:0] hd_rnd, hd_nxt, hd_r;
  logic                 rd_v_r;

  always_comb begin
    hsum   = {1'b0, h_r} + ROUND_HALF;
    hd_rnd = hsum[HW-1:ROUND_SHIFT];
    hd_nxt = (hd_rnd >= HEADING_FULL) ? '0 : hd_rnd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else if (en) begin
      rd_v_r <= qd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hd_r <= hd_nxt;
    end
  end

  assign res_v       = rd_v_r;
  assign res_heading = hd_r;

endmodule

FILE: rtl/compass_heading_from_xy.sv
// ----------------------------------------------------------------------------
// compass_heading_from_xy: magnetometer x/y pair to compass heading
// Pipelined cordic atan2, heading folded into 0..360 degrees in 1/64 degree
// units, followed by an output register with a one-word skid stage.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                 payload
//   in_       input      in_valid / in_ready       in_field_x, in_field_y
//   out_      output     out_valid / out_ready     out_heading
//
// accepts one word per cycle while in_ready is high; words pass through the
// input register, one cordic micro-rotation per stage, then the clamp, fold,
// round and output registers
// synchronous active-low reset empties the pipeline, skid and output register
// in_ready is registered: it drops only while the skid word is held, which
// freezes the whole pipeline until the output register drains
//
module compass_heading_from_xy #(
  parameter int ITERATIONS = chxy_pkg::ITERATIONS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [chxy_pkg::FIELD_W-1:0] in_field_x,
  input  logic signed [chxy_pkg::FIELD_W-1:0] in_field_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [chxy_pkg::HEADING_W-1:0]      out_heading
);
  import chxy_pkg::*;

  logic                 pipe_en;
  logic                 res_v;
  logic [HEADING_W-1:0] res_heading;

  logic                 out_v_r, out_v_nxt;
  logic [HEADING_W-1:0] out_hd_r, out_hd_nxt;
  logic                 skid_v_r, skid_v_nxt;
  logic [HEADING_W-1:0] skid_hd_r, skid_hd_nxt;

  // pipeline moves whenever the skid stage is empty
  assign pipe_en  = !skid_v_r;
  assign in_ready = pipe_en;

  chxy_cordic #(
    .ITERATIONS (ITERATIONS)
  ) u_cordic (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (pipe_en),
    .in_v        (in_valid),
    .field_x     (in_field_x),
    .field_y     (in_field_y),
    .res_v       (res_v),
    .res_heading (res_heading)
  );

  // output register and skid stage
  always_comb begin
    out_v_nxt   = out_v_r && !out_ready;
    out_hd_nxt  = out_hd_r;
    skid_v_nxt  = skid_v_r;
    skid_hd_nxt = skid_hd_r;
    if (skid_v_r) begin
      if (out_ready) begin
        out_v_nxt  = 1'b1;
        out_hd_nxt = skid_hd_r;
        skid_v_nxt = 1'b0;
      end
    end else if (res_v) begin
      if (!out_v_r || out_ready) begin
        out_v_nxt  = 1'b1;
        out_hd_nxt = res_heading;
      end else begin
        skid_v_nxt  = 1'b1;
        skid_hd_nxt = res_heading;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hd_r  <= out_hd_nxt;
    skid_hd_r <= skid_hd_nxt;
  end

  assign out_valid   = out_v_r;
  assign out_heading = out_hd_r;

  // checks
`ifndef ASSERT_OFF
  // skid word only exists behind a held output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid word held with empty output register");

  // skid fills only when the output word was stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_ready && res_v))
    else $error("skid filled without a stalled output word");

  // skid word is kept while the output stays stalled
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_ready |=> skid_v_r && $stable(skid_hd_r))
    else $error("skid word lost during stall");

  // heading never reaches a full turn
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_hd_r < HEADING_FULL)
    else $error("heading out of range");
`endif

endmodule
